// File: hdl/rtct_pkg.sv
// shared types and constants for the reset token connection id table
// used by rtct_cell and reset_token_cid_table; no dependencies
`default_nettype none

package rtct_pkg;

	localparam int ENTRIES      = 8;
	localparam int MAX_ID_BYTES = 20;
	localparam int TOKEN_BYTES  = 16;

	localparam int LEN_W = 5;
	localparam int ID_W  = MAX_ID_BYTES * 8;
	localparam int TOK_W = TOKEN_BYTES * 8;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	typedef enum logic {
		OP_ADD  = 1'b0,
		OP_FIND = 1'b1
	} op_t;

	// one item as broadcast to every cell
	typedef struct packed {
		op_t               op;
		logic [LEN_W-1:0]  len;
		logic [ID_W-1:0]   id;
		logic [ID_W-1:0]   mask;
		logic [TOK_W-1:0]  token;
	} key_t;

	// priority link between neighboring cells
	typedef struct packed {
		logic             hit;
		logic [TOK_W-1:0] token;
	} link_t;

	// ones over every id byte below len, byte 0 in the top bits
	function automatic logic [ID_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
		logic [ID_W-1:0] m;
		m = '0;
		for (int i = 0; i < MAX_ID_BYTES; i++) begin
			if (LEN_W'(i) < len) begin
				m[ID_W-1-8*i -: 8] = 8'hff;
			end
		end
		return m;
	endfunction

endpackage

`default_nettype wire

// File: hdl/rtct_cell.sv
// one table entry: stored id, length and token, a compare and a priority link
// depends on rtct_pkg
`default_nettype none

module rtct_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  wire logic            cmp_en,
	input  wire rtct_pkg::key_t  key,
	input  wire rtct_pkg::link_t link_in,
	output rtct_pkg::link_t      link_out
);

	logic                          valid_q;
	logic                          hit_q;
	logic [rtct_pkg::LEN_W-1:0]    len_q;
	logic [rtct_pkg::ID_W-1:0]     id_q;
	logic [rtct_pkg::TOK_W-1:0]    tok_q;
	logic                          match;

	assign match = valid_q && (len_q == key.len) && (((id_q ^ key.id) & key.mask) == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q <= 1'b1;
			end
			if (cmp_en) begin
				hit_q <= match;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			len_q <= key.len;
			id_q  <= key.id;
			tok_q <= key.token;
		end
	end

	// earlier entry wins
	always_comb begin
		link_out.hit = link_in.hit | hit_q;
		if (link_in.hit) begin
			link_out.token = link_in.token;
		end else if (hit_q) begin
			link_out.token = tok_q;
		end else begin
			link_out.token = '0;
		end
	end

endmodule

`default_nettype wire

// File: hdl/reset_token_cid_table.sv
// top level of the reset token connection id table: control, output register
// and the row of rtct_cell entries; depends on rtct_pkg and rtct_cell
`default_nettype none

// channel | handshake            | word
// --------+----------------------+------------------------------------------------
// in      | in_valid / in_ready  | func, cid_len, cid_word0..2, token_hi, token_lo
// out     | out_valid / out_ready| ok, found_token_hi, found_token_lo
//
// each word passes a compare cycle in which every cell checks the
// registered key in parallel (and an add writes the next free cell), then a
// select cycle in which the hits ripple down the cell row, first entry winning
// the next word is taken during the select cycle as long as the output register
// is free or being drained, so a new word enters while the last one is selected
// reset clears the entry count and the cell valid bits at once; no sweep needed
// a stalled output holds the block in the select cycle, no word is lost

module reset_token_cid_table (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        func,
	input  wire logic [4:0]  cid_len,
	input  wire logic [63:0] cid_word0,
	input  wire logic [63:0] cid_word1,
	input  wire logic [31:0] cid_word2,
	input  wire logic [63:0] token_hi,
	input  wire logic [63:0] token_lo,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             ok,
	output logic [63:0]      found_token_hi,
	output logic [63:0]      found_token_lo
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CMP  = 3'b010,
		S_SEL  = 3'b100
	} state_t;

	state_t                       state_q;
	rtct_pkg::key_t               key_q;
	rtct_pkg::key_t               key_in;
	logic [rtct_pkg::CNT_W-1:0]   count_q;
	logic                         add_ok_q;
	logic                         add_ok;
	logic                         in_acc;
	logic                         out_free;
	logic                         sel_done;
	logic                         out_valid_q;
	logic                         ok_q;
	logic [rtct_pkg::TOK_W-1:0]   found_q;
	logic [rtct_pkg::ENTRIES-1:0] wr_en;
	logic [159:0]                 id_full;
	rtct_pkg::link_t              link [0:rtct_pkg::ENTRIES];

	// incoming word, id bytes packed with byte 0 on top
	assign id_full       = {cid_word0, cid_word1, cid_word2};
	assign key_in.op     = rtct_pkg::op_t'(func);
	assign key_in.len    = cid_len;
	assign key_in.id     = id_full[159 -: rtct_pkg::ID_W];
	assign key_in.mask   = rtct_pkg::byte_mask(cid_len);
	assign key_in.token  = {token_hi, token_lo};

	assign out_free = !out_valid_q || out_ready;
	assign sel_done = (state_q == S_SEL) && out_free;
	assign in_ready = (state_q == S_IDLE) || sel_done;
	assign in_acc   = in_valid && in_ready;

	// add lands only with a free entry and a legal length
	assign add_ok = (key_q.op == rtct_pkg::OP_ADD)
		&& (count_q < rtct_pkg::CNT_W'(rtct_pkg::ENTRIES))
		&& (key_q.len <= rtct_pkg::LEN_W'(rtct_pkg::MAX_ID_BYTES));

	// the cell row: each cell hands the first hit so far to its neighbor
	assign link[0] = '0;

	for (genvar g = 0; g < rtct_pkg::ENTRIES; g++) begin : g_cell
		assign wr_en[g] = (state_q == S_CMP) && add_ok
			&& (count_q == rtct_pkg::CNT_W'(g));

		rtct_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (wr_en[g]),
			.cmp_en   (state_q == S_CMP),
			.key      (key_q),
			.link_in  (link[g]),
			.link_out (link[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_SEL;
					if (add_ok) begin
						count_q <= count_q + 1'b1;
					end
				end
				S_SEL: begin
					if (sel_done) begin
						state_q <= in_acc ? S_CMP : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (sel_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			key_q <= key_in;
		end
		if (state_q == S_CMP) begin
			add_ok_q <= add_ok;
		end
		if (sel_done) begin
			if (key_q.op == rtct_pkg::OP_ADD) begin
				ok_q    <= add_ok_q;
				found_q <= '0;
			end else begin
				ok_q    <= link[rtct_pkg::ENTRIES].hit;
				found_q <= link[rtct_pkg::ENTRIES].token;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign ok             = ok_q;
	assign found_token_hi = found_q[127:64];
	assign found_token_lo = found_q[63:0];

	// entry count stays within the table
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rtct_pkg::CNT_W'(rtct_pkg::ENTRIES))
		else $error("entry count beyond table size");

	// the count moves only in the compare cycle
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_CMP |=> $stable(count_q))
		else $error("entry count changed outside compare cycle");

	// compare is always followed by select
	a_cmp_to_sel: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |=> state_q == S_SEL)
		else $error("compare not followed by select");

	// a stalled output keeps the block in select
	a_sel_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEL) && out_valid_q && !out_ready |=> state_q == S_SEL)
		else $error("select left while output stalled");

	// at most one cell written per word
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(wr_en))
		else $error("more than one cell written");

endmodule

`default_nettype wire

// File: bench/tb_reset_token_cid_table.sv
// self-checking testbench for reset_token_cid_table: directed and random add/find words
// against a shadow copy of the table; depends on rtct_pkg and the block's rtl
`timescale 1ns / 100ps

module tb_reset_token_cid_table;

	import rtct_pkg::*;

	// one word on the input channel, plus a flag that makes the sender drain first
	typedef struct packed {
		op_t              op;
		logic [LEN_W-1:0] len;
		logic [ID_W-1:0]  id;
		logic [TOK_W-1:0] token;
		logic             drain_first;
	} cmd_word_t;

	// one word on the output channel
	typedef struct packed {
		logic        ok;
		logic [63:0] tok_hi;
		logic [63:0] tok_lo;
	} table_reply_t;

	localparam int RANDOM_WORDS = 1125;
	localparam int PRINT_CAP    = 50;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        func = 1'b0;
	logic [4:0]  cid_len = '0;
	logic [63:0] cid_word0 = '0;
	logic [63:0] cid_word1 = '0;
	logic [31:0] cid_word2 = '0;
	logic [63:0] token_hi = '0;
	logic [63:0] token_lo = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        ok;
	logic [63:0] found_token_hi;
	logic [63:0] found_token_lo;

	cmd_word_t    words_to_send[$];
	table_reply_t replies_due[$];
	int           mismatches = 0;
	int           cycle = 0;
	cmd_word_t    next_word;
	table_reply_t want;

	// shadow copy of the table contents
	int               shadow_count = 0;
	logic [LEN_W-1:0] shadow_len[ENTRIES];
	logic [ID_W-1:0]  shadow_id[ENTRIES];
	logic [TOK_W-1:0] shadow_token[ENTRIES];

	// ids planted by the directed adds, reused to build hits later
	logic [LEN_W-1:0] planted_len[ENTRIES];
	logic [ID_W-1:0]  planted_id[ENTRIES];

	// window of cycles in which neither side idles
	wire calm = (cycle >= 1200) && (cycle < 2000);

	reset_token_cid_table u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.cid_len        (cid_len),
		.cid_word0      (cid_word0),
		.cid_word1      (cid_word1),
		.cid_word2      (cid_word2),
		.token_hi       (token_hi),
		.token_lo       (token_lo),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.ok             (ok),
		.found_token_hi (found_token_hi),
		.found_token_lo (found_token_lo)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ones over every id byte below len, byte 0 at the top
	function automatic logic [ID_W-1:0] id_prefix_mask(input logic [LEN_W-1:0] len);
		logic [ID_W-1:0] m;
		m = '0;
		for (int i = 0; i < MAX_ID_BYTES; i++) begin
			if (i < int'(len)) begin
				m[ID_W-1-8*i -: 8] = 8'hff;
			end
		end
		return m;
	endfunction

	// applies one accepted word to the shadow table and returns the reply it must cause
	function automatic table_reply_t predict_table_response(input cmd_word_t w);
		table_reply_t    r;
		logic [ID_W-1:0] m;
		bit              hit;
		r = '0;
		hit = 1'b0;
		if (w.op == OP_ADD) begin
			// room left and a legal length, else rejected with nothing stored
			if (shadow_count < ENTRIES && int'(w.len) <= MAX_ID_BYTES) begin
				shadow_len[shadow_count] = w.len;
				shadow_id[shadow_count] = w.id & id_prefix_mask(w.len);
				shadow_token[shadow_count] = w.token;
				shadow_count++;
				r.ok = 1'b1;
			end
		end else begin
			// first match in insertion order wins; bytes past the length never count
			m = id_prefix_mask(w.len);
			for (int e = 0; e < shadow_count; e++) begin
				if (!hit && shadow_len[e] == w.len && ((shadow_id[e] ^ w.id) & m) == '0) begin
					hit = 1'b1;
					r.ok = 1'b1;
					r.tok_hi = shadow_token[e][TOK_W-1 -: 64];
					r.tok_lo = shadow_token[e][63:0];
				end
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < PRINT_CAP) begin
			$display("[%0t] mismatch: %s", $realtime, msg);
		end
		mismatches++;
	endtask

	function automatic logic [ID_W-1:0] rand_id();
		return {$urandom, $urandom, $urandom, $urandom, $urandom};
	endfunction

	function automatic logic [TOK_W-1:0] rand_token();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	task automatic queue_word(input op_t op, input int len, input logic [ID_W-1:0] id,
			input logic [TOK_W-1:0] token, input bit drain);
		cmd_word_t w;
		w.op = op;
		w.len = LEN_W'(len);
		w.id = id;
		w.token = token;
		w.drain_first = drain;
		words_to_send.push_back(w);
	endtask

	// driver: offers the next pending word, predicts each accepted one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				replies_due.push_back(predict_table_response({op_t'(func), cid_len,
					cid_word0, cid_word1, cid_word2, token_hi, token_lo, 1'b0}));
			end
			if (!in_valid || in_ready) begin
				// a drain-first word waits until every reply is back
				if (words_to_send.size() != 0
						&& !(words_to_send[0].drain_first && replies_due.size() != 0)
						&& (calm || $urandom_range(99) >= 10)) begin
					next_word = words_to_send.pop_front();
					in_valid  <= 1'b1;
					func      <= next_word.op;
					cid_len   <= next_word.len;
					cid_word0 <= next_word.id[159:96];
					cid_word1 <= next_word.id[95:32];
					cid_word2 <= next_word.id[31:0];
					token_hi  <= next_word.token[127:64];
					token_lo  <= next_word.token[63:0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: random back-pressure and in-order compare of every reply word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			cycle     <= 0;
		end else begin
			cycle     <= cycle + 1;
			out_ready <= calm || ($urandom_range(99) >= 10);
			if (out_valid && out_ready) begin
				if (replies_due.size() == 0) begin
					report_mismatch($sformatf("reply word with none expected, ok=%0b", ok));
				end else begin
					want = replies_due.pop_front();
					if (ok !== want.ok) begin
						report_mismatch($sformatf("ok got %0b want %0b", ok, want.ok));
					end
					if (found_token_hi !== want.tok_hi) begin
						report_mismatch($sformatf("found_token_hi got %h want %h",
							found_token_hi, want.tok_hi));
					end
					if (found_token_lo !== want.tok_lo) begin
						report_mismatch($sformatf("found_token_lo got %h want %h",
							found_token_lo, want.tok_lo));
					end
				end
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		logic [ID_W-1:0] m;
		logic [ID_W-1:0] id;
		int              k;
		int              r;
		int              len;

		// entries the directed part plants, in insertion order
		planted_len[0] = 5'd0;  planted_id[0] = rand_id();
		planted_len[1] = 5'd20; planted_id[1] = '1;
		planted_len[2] = 5'd20; planted_id[2] = '0;
		planted_len[3] = 5'd1;  planted_id[3] = rand_id();
		planted_id[3][ID_W-1 -: 8] = 8'ha5;
		planted_len[4] = 5'd8;  planted_id[4] = rand_id();
		planted_len[5] = 5'd9;  planted_id[5] = rand_id();
		planted_len[6] = 5'd17; planted_id[6] = rand_id();
		// same id as entry 4 with other bytes past the length: a later duplicate
		planted_len[7] = 5'd8;
		m = id_prefix_mask(5'd8);
		planted_id[7] = (planted_id[4] & m) | (rand_id() & ~m);

		// find on an empty table misses
		queue_word(OP_FIND, 0, rand_id(), rand_token(), 1'b0);
		// lengths above the maximum are rejected
		queue_word(OP_ADD, 21, rand_id(), rand_token(), 1'b0);
		queue_word(OP_ADD, 31, '1, '1, 1'b0);
		// fill the table, extreme tokens on the first entries
		queue_word(OP_ADD, int'(planted_len[0]), planted_id[0], '1, 1'b0);
		queue_word(OP_ADD, int'(planted_len[1]), planted_id[1], rand_token(), 1'b0);
		queue_word(OP_ADD, int'(planted_len[2]), planted_id[2], '0, 1'b0);
		for (int e = 3; e < ENTRIES; e++) begin
			queue_word(OP_ADD, int'(planted_len[e]), planted_id[e], rand_token(), 1'b0);
		end
		// table full rejects
		queue_word(OP_ADD, 5, rand_id(), rand_token(), 1'b0);
		queue_word(OP_ADD, 0, rand_id(), rand_token(), 1'b0);
		// hits with garbage past the length; the duplicate returns the older token
		for (int e = 0; e < ENTRIES; e++) begin
			m = id_prefix_mask(LEN_W'(planted_len[e]));
			queue_word(OP_FIND, int'(planted_len[e]), (planted_id[e] & m) | (rand_id() & ~m),
				rand_token(), 1'b0);
		end
		// misses: over-long lengths, a length no entry has, one flipped bit
		queue_word(OP_FIND, 21, '1, rand_token(), 1'b0);
		queue_word(OP_FIND, 31, '1, rand_token(), 1'b0);
		queue_word(OP_FIND, 19, '1, rand_token(), 1'b0);
		queue_word(OP_FIND, 20, {{(ID_W-1){1'b1}}, 1'b0}, rand_token(), 1'b0);

		// random part, mostly lookups of stored ids with random tails
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			r = $urandom_range(99);
			k = $urandom_range(ENTRIES - 1);
			len = int'(planted_len[k]);
			m = id_prefix_mask(LEN_W'(len));
			id = (planted_id[k] & m) | (rand_id() & ~m);
			if (r < 60) begin
				queue_word(OP_FIND, len, id, rand_token(), n == 0 || n == 600);
			end else if (r < 70) begin
				// near miss: one bit flipped inside the id, or a shifted length
				if (len > 0) begin
					id[ID_W-1 - $urandom_range(8*len - 1)] ^= 1'b1;
				end else begin
					len = $urandom_range(1, MAX_ID_BYTES);
				end
				queue_word(OP_FIND, len, id, rand_token(), n == 0 || n == 600);
			end else if (r < 85) begin
				queue_word(OP_FIND, $urandom_range(31), rand_id(), rand_token(),
					n == 0 || n == 600);
			end else begin
				queue_word(OP_ADD, $urandom_range(31), rand_id(), rand_token(),
					n == 0 || n == 600);
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (words_to_send.size() != 0 || in_valid || replies_due.size() != 0) begin
			@(posedge clk);
		end
		// keep the clock running to catch any stray reply word
		repeat (20) @(posedge clk);

		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#100000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
